// ----- src/qet_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qet_pkg
// Shared widths, operation codes, status type and saturating fixed-point
// helpers for the quartic escape-time block.
// ----------------------------------------------------------------------------
package qet_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 28;
    localparam int COUNT_WIDTH = 16;

    // Exact product width and the widest magnitude handled by the saturator.
    localparam int PW = 2 * DATA_WIDTH;
    localparam int MW = 2 * DATA_WIDTH + 1;

    // The divider walks all dividend bits, then FRAC_BITS-1 extra zero bits.
    localparam int DIV_STEPS = PW + FRAC_BITS - 1;
    localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

    localparam int ADDR_WIDTH = 5;
    localparam int IDX_WIDTH  = ADDR_WIDTH - 2;

    localparam logic [IDX_WIDTH-1:0] REG_CRIT_RE  = IDX_WIDTH'(0);
    localparam logic [IDX_WIDTH-1:0] REG_CRIT_IM  = IDX_WIDTH'(1);
    localparam logic [IDX_WIDTH-1:0] REG_MULT_RE  = IDX_WIDTH'(2);
    localparam logic [IDX_WIDTH-1:0] REG_MULT_IM  = IDX_WIDTH'(3);
    localparam logic [IDX_WIDTH-1:0] REG_MAX_ITER = IDX_WIDTH'(4);

    localparam logic [COUNT_WIDTH-1:0] MAX_ITER_RESET = COUNT_WIDTH'(50);

    localparam logic [MW-1:0] ESC_RADIUS_SQ = MW'(1000);

    typedef logic signed [DATA_WIDTH-1:0] fix_t;
    typedef logic [COUNT_WIDTH-1:0]       count_t;

    typedef struct packed {
        logic sat;
        fix_t val;
    } sfix_t;

    // Datapath operation codes issued by the controller.
    typedef logic [4:0] op_t;
    localparam op_t OP_IDLE      = 5'd0;
    localparam op_t OP_LOAD      = 5'd1;
    localparam op_t OP_T1        = 5'd2;
    localparam op_t OP_T2        = 5'd3;
    localparam op_t OP_T3        = 5'd4;
    localparam op_t OP_MUL_TC    = 5'd5;
    localparam op_t OP_MUL_NC    = 5'd6;
    localparam op_t OP_MUL_CC    = 5'd7;
    localparam op_t OP_MUL_PP    = 5'd8;
    localparam op_t OP_MUL_XP    = 5'd9;
    localparam op_t OP_CMB_N     = 5'd10;
    localparam op_t OP_ADD_NL    = 5'd11;
    localparam op_t OP_DSUM      = 5'd12;
    localparam op_t OP_DEN       = 5'd13;
    localparam op_t OP_DIV_START = 5'd14;
    localparam op_t OP_B         = 5'd15;
    localparam op_t OP_BZERO     = 5'd16;
    localparam op_t OP_PINIT     = 5'd17;
    localparam op_t OP_XSUB      = 5'd18;
    localparam op_t OP_CMB_X     = 5'd19;
    localparam op_t OP_ADD_XB    = 5'd20;
    localparam op_t OP_ADD_XL    = 5'd21;
    localparam op_t OP_CMB_P     = 5'd22;

    typedef struct packed {
        logic outside;
        logic escaped;
        logic limit_hit;
        logic den_zero;
        logic div_done;
    } dp_status_t;

    localparam fix_t FIX_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam fix_t FIX_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    function automatic sfix_t sat_add(input fix_t x, input fix_t y);
        logic [DATA_WIDTH:0] s;
        sfix_t r;
        s = {x[DATA_WIDTH-1], x} + {y[DATA_WIDTH-1], y};
        r.sat = (s[DATA_WIDTH] != s[DATA_WIDTH-1]);
        if (r.sat)
        begin
            r.val = s[DATA_WIDTH] ? FIX_MIN : FIX_MAX;
        end
        else
        begin
            r.val = fix_t'(s[DATA_WIDTH-1:0]);
        end
        return r;
    endfunction

    function automatic sfix_t sat_sub(input fix_t x, input fix_t y);
        logic [DATA_WIDTH:0] s;
        sfix_t r;
        s = {x[DATA_WIDTH-1], x} - {y[DATA_WIDTH-1], y};
        r.sat = (s[DATA_WIDTH] != s[DATA_WIDTH-1]);
        if (r.sat)
        begin
            r.val = s[DATA_WIDTH] ? FIX_MIN : FIX_MAX;
        end
        else
        begin
            r.val = fix_t'(s[DATA_WIDTH-1:0]);
        end
        return r;
    endfunction

    // Sign and magnitude to a saturated fixed-point value.
    function automatic sfix_t sat_mag(input logic neg, input logic [MW-1:0] mag);
        logic [MW-1:0] lim;
        sfix_t r;
        lim = {{(DATA_WIDTH+2){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
        r.sat = 1'b0;
        if (!neg)
        begin
            if (mag > lim)
            begin
                r.sat = 1'b1;
                r.val = FIX_MAX;
            end
            else
            begin
                r.val = fix_t'(mag[DATA_WIDTH-1:0]);
            end
        end
        else
        begin
            if (mag > lim + MW'(1))
            begin
                r.sat = 1'b1;
                r.val = FIX_MIN;
            end
            else
            begin
                r.val = fix_t'(0) - fix_t'(mag[DATA_WIDTH-1:0]);
            end
        end
        return r;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] mag_of(input fix_t x);
        logic [DATA_WIDTH-1:0] r;
        r = x[DATA_WIDTH-1] ? (~x + 1'b1) : x;
        return r;
    endfunction

endpackage

// ----- src/quartic_escape_time_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quartic_escape_time_top
// Escape-time iteration of a quartic map for one parameter point per command.
// ----------------------------------------------------------------------------
//  Channel   Handshake                         Beat contents
//  input     start high, busy low              point_re, point_im
//  result    done high for one cycle           escape_count, stayed_bounded
//  config    psel, penable, pwrite (pready=1)  paddr, pwdata / prdata
//
//  For each item the offset set-up, bounded by the two bit-serial dividers,
//  runs first, then the escape-time loop; each iteration runs the |p|^2
//  test and three complex products through one multiplier bank. A new point
//  is accepted the cycle after done. rst_n clears the sequencer and loads
//  the register defaults; the result side is never stalled.
// ----------------------------------------------------------------------------
module quartic_escape_time_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  qet_pkg::fix_t                  point_re,
    input  qet_pkg::fix_t                  point_im,
    output logic                           done,
    output qet_pkg::count_t                escape_count,
    output logic                           stayed_bounded,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qet_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import qet_pkg::*;

    fix_t       crit_re, crit_im, mult_re, mult_im;
    count_t     max_iterations;
    op_t        cmd;
    dp_status_t status;

    qet_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .crit_re        (crit_re),
        .crit_im        (crit_im),
        .mult_re        (mult_re),
        .mult_im        (mult_im),
        .max_iterations (max_iterations)
    );

    qet_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .point_re       (point_re),
        .point_im       (point_im),
        .crit_re        (crit_re),
        .crit_im        (crit_im),
        .mult_re        (mult_re),
        .mult_im        (mult_im),
        .max_iterations (max_iterations),
        .status         (status),
        .escape_count   (escape_count),
        .stayed_bounded (stayed_bounded)
    );

    qet_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

endmodule

// ----- src/qet_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qet_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module qet_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qet_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output qet_pkg::fix_t                  crit_re,
    output qet_pkg::fix_t                  crit_im,
    output qet_pkg::fix_t                  mult_re,
    output qet_pkg::fix_t                  mult_im,
    output qet_pkg::count_t                max_iterations
);
    import qet_pkg::*;

    logic [IDX_WIDTH-1:0] idx;
    logic                 wr_en;
    fix_t                 crit_re_reg;
    fix_t                 crit_im_reg;
    fix_t                 mult_re_reg;
    fix_t                 mult_im_reg;
    count_t               max_iter_reg;

    assign idx    = paddr[ADDR_WIDTH-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crit_re_reg  <= fix_t'(1) <<< FRAC_BITS;
            crit_im_reg  <= '0;
            mult_re_reg  <= fix_t'(1) <<< FRAC_BITS;
            mult_im_reg  <= '0;
            max_iter_reg <= MAX_ITER_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_CRIT_RE:  crit_re_reg  <= fix_t'(pwdata[DATA_WIDTH-1:0]);
                REG_CRIT_IM:  crit_im_reg  <= fix_t'(pwdata[DATA_WIDTH-1:0]);
                REG_MULT_RE:  mult_re_reg  <= fix_t'(pwdata[DATA_WIDTH-1:0]);
                REG_MULT_IM:  mult_im_reg  <= fix_t'(pwdata[DATA_WIDTH-1:0]);
                REG_MAX_ITER: max_iter_reg <= pwdata[COUNT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_CRIT_RE:  prdata = 32'(crit_re_reg);
            REG_CRIT_IM:  prdata = 32'(crit_im_reg);
            REG_MULT_RE:  prdata = 32'(mult_re_reg);
            REG_MULT_IM:  prdata = 32'(mult_im_reg);
            REG_MAX_ITER: prdata = 32'(max_iter_reg);
            default:      prdata = '0;
        endcase
    end

    assign crit_re        = crit_re_reg;
    assign crit_im        = crit_im_reg;
    assign mult_re        = mult_re_reg;
    assign mult_im        = mult_im_reg;
    assign max_iterations = max_iter_reg;

endmodule

// ----- src/qet_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qet_div
// Restoring divider, one quotient bit per cycle, giving
// floor(dividend * 2^(FRAC_BITS-1) / divisor) with a sticky overflow flag.
// ----------------------------------------------------------------------------
module qet_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [qet_pkg::PW-1:0]    dividend,
    input  logic [qet_pkg::PW-1:0]    divisor,
    output logic                      done,
    output logic                      big,
    output logic [qet_pkg::DATA_WIDTH:0] quot
);
    import qet_pkg::*;

    logic                  run_reg;
    logic                  done_reg;
    logic [DIV_CW-1:0]     cnt_reg;
    logic [PW-1:0]         dvd_reg;
    logic [PW:0]           rem_reg;
    logic [DATA_WIDTH:0]   quot_reg;
    logic                  big_reg;
    logic [PW:0]           rem_sh;
    logic                  ge;

    assign rem_sh = {rem_reg[PW-1:0], dvd_reg[PW-1]};
    assign ge     = (rem_sh >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CW'(DIV_STEPS);
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == DIV_CW'(1));
            if (run_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CW'(1);
                if (cnt_reg == DIV_CW'(1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= dividend;
            rem_reg  <= '0;
            quot_reg <= '0;
            big_reg  <= 1'b0;
        end
        else if (run_reg)
        begin
            dvd_reg  <= {dvd_reg[PW-2:0], 1'b0};
            rem_reg  <= ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
            quot_reg <= {quot_reg[DATA_WIDTH-1:0], ge};
            // Any quotient beyond this width saturates later anyway.
            big_reg  <= big_reg | quot_reg[DATA_WIDTH];
        end
    end

    assign done = done_reg;
    assign big  = big_reg;
    assign quot = quot_reg;

endmodule

// ----- src/qet_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qet_dpath
// Datapath: operand registers, a four-multiplier complex product bank,
// saturating adders, the escape test and two dividers for the offset b.
// ----------------------------------------------------------------------------
module qet_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  qet_pkg::op_t        cmd,
    input  qet_pkg::fix_t       point_re,
    input  qet_pkg::fix_t       point_im,
    input  qet_pkg::fix_t       crit_re,
    input  qet_pkg::fix_t       crit_im,
    input  qet_pkg::fix_t       mult_re,
    input  qet_pkg::fix_t       mult_im,
    input  qet_pkg::count_t     max_iterations,
    output qet_pkg::dp_status_t status,
    output qet_pkg::count_t     escape_count,
    output logic                stayed_bounded
);
    import qet_pkg::*;

    typedef struct packed {
        logic          neg;
        logic [PW-1:0] mag;
    } sm_t;

    function automatic sm_t sm_sum(input logic n1, input logic [PW-1:0] m1,
                                   input logic n2, input logic [PW-1:0] m2);
        sm_t r;
        if (n1 == n2)
        begin
            r.neg = n1;
            r.mag = m1 + m2;
        end
        else if (m1 >= m2)
        begin
            r.neg = n1;
            r.mag = m1 - m2;
        end
        else
        begin
            r.neg = n2;
            r.mag = m2 - m1;
        end
        return r;
    endfunction

    fix_t a_re_reg, a_im_reg, a_re_next, a_im_next;
    fix_t t_re_reg, t_im_reg, t_re_next, t_im_next;
    fix_t f_re_reg, f_im_reg, f_re_next, f_im_next;
    fix_t n_re_reg, n_im_reg, n_re_next, n_im_next;
    fix_t x_re_reg, x_im_reg, x_re_next, x_im_next;
    fix_t p_re_reg, p_im_reg, p_re_next, p_im_next;
    fix_t b_re_reg, b_im_reg, b_re_next, b_im_next;
    logic [PW-1:0] mr_reg, mi_reg, mr_next, mi_next;
    logic [PW-1:0] den_reg, den_next;
    logic          negr_reg, negi_reg, negr_next, negi_next;
    logic          bsat_reg, bsat_next;
    logic          s_reg, s_next;
    count_t        count_reg, count_next;

    logic [PW-1:0] prod0_reg, prod1_reg, prod2_reg, prod3_reg;
    logic          sxr_reg, sxi_reg, syr_reg, syi_reg;

    fix_t                  mx_re, mx_im, my_re, my_im;
    logic                  bank_en;
    logic [DATA_WIDTH-1:0] ax_re, ax_im, ay_re, ay_im;

    sfix_t f0, f1, f2, f3, cmb_re, cmb_im;
    logic  cmb_sat;
    sm_t   sum_r, sum_i;

    logic [MW-1:0]       osum;
    logic                div_go;
    logic                done_re, done_im, big_re, big_im;
    logic [DATA_WIDTH:0] quot_re, quot_im;

    // Operand selection for the product bank.
    always_comb
    begin
        bank_en = 1'b1;
        mx_re   = x_re_reg;
        mx_im   = x_im_reg;
        my_re   = p_re_reg;
        my_im   = p_im_reg;
        unique case (cmd)
            OP_MUL_TC:
            begin
                mx_re = t_re_reg;
                mx_im = t_im_reg;
                my_re = crit_re;
                my_im = crit_im;
            end
            OP_MUL_NC:
            begin
                mx_re = n_re_reg;
                mx_im = n_im_reg;
                my_re = crit_re;
                my_im = crit_im;
            end
            OP_MUL_CC:
            begin
                mx_re = crit_re;
                mx_im = crit_im;
                my_re = crit_re;
                my_im = crit_im;
            end
            OP_MUL_PP:
            begin
                mx_re = p_re_reg;
                mx_im = p_im_reg;
            end
            OP_MUL_XP: ;
            default: bank_en = 1'b0;
        endcase
    end

    assign ax_re = mag_of(mx_re);
    assign ax_im = mag_of(mx_im);
    assign ay_re = mag_of(my_re);
    assign ay_im = mag_of(my_im);

    always_ff @(posedge clk)
    begin
        if (bank_en)
        begin
            prod0_reg <= PW'(ax_re) * PW'(ay_re);
            prod1_reg <= PW'(ax_im) * PW'(ay_im);
            prod2_reg <= PW'(ax_re) * PW'(ay_im);
            prod3_reg <= PW'(ax_im) * PW'(ay_re);
            sxr_reg   <= mx_re[DATA_WIDTH-1];
            sxi_reg   <= mx_im[DATA_WIDTH-1];
            syr_reg   <= my_re[DATA_WIDTH-1];
            syi_reg   <= my_im[DATA_WIDTH-1];
        end
    end

    // Scaling of the four products, truncating toward zero, and the complex combine.
    assign f0 = sat_mag(sxr_reg ^ syr_reg, {1'b0, prod0_reg} >> FRAC_BITS);
    assign f1 = sat_mag(sxi_reg ^ syi_reg, {1'b0, prod1_reg} >> FRAC_BITS);
    assign f2 = sat_mag(sxr_reg ^ syi_reg, {1'b0, prod2_reg} >> FRAC_BITS);
    assign f3 = sat_mag(sxi_reg ^ syr_reg, {1'b0, prod3_reg} >> FRAC_BITS);
    assign cmb_re  = sat_sub(f0.val, f1.val);
    assign cmb_im  = sat_add(f2.val, f3.val);
    assign cmb_sat = f0.sat | f1.sat | f2.sat | f3.sat | cmb_re.sat | cmb_im.sat;

    // Numerator times conj(c), kept exact in sign and magnitude.
    assign sum_r = sm_sum(sxr_reg ^ syr_reg, prod0_reg, sxi_reg ^ syi_reg, prod1_reg);
    assign sum_i = sm_sum(sxi_reg ^ syr_reg, prod3_reg, ~(sxr_reg ^ syi_reg), prod2_reg);

    assign osum = {1'b0, prod0_reg} + {1'b0, prod1_reg};

    assign div_go = (cmd == OP_DIV_START);

    qet_div u_div_re (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go),
        .dividend (mr_reg),
        .divisor  (den_reg),
        .done     (done_re),
        .big      (big_re),
        .quot     (quot_re)
    );

    qet_div u_div_im (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go),
        .dividend (mi_reg),
        .divisor  (den_reg),
        .done     (done_im),
        .big      (big_im),
        .quot     (quot_im)
    );

    always_comb
    begin
        sfix_t r0, r1, r2, r3;
        r0 = '0;
        r1 = '0;
        r2 = '0;
        r3 = '0;
        a_re_next  = a_re_reg;
        a_im_next  = a_im_reg;
        t_re_next  = t_re_reg;
        t_im_next  = t_im_reg;
        f_re_next  = f_re_reg;
        f_im_next  = f_im_reg;
        n_re_next  = n_re_reg;
        n_im_next  = n_im_reg;
        x_re_next  = x_re_reg;
        x_im_next  = x_im_reg;
        p_re_next  = p_re_reg;
        p_im_next  = p_im_reg;
        b_re_next  = b_re_reg;
        b_im_next  = b_im_reg;
        mr_next    = mr_reg;
        mi_next    = mi_reg;
        negr_next  = negr_reg;
        negi_next  = negi_reg;
        den_next   = den_reg;
        bsat_next  = bsat_reg;
        s_next     = s_reg;
        count_next = count_reg;
        unique case (cmd)
            OP_LOAD:
            begin
                a_re_next = point_re;
                a_im_next = point_im;
                bsat_next = 1'b0;
            end
            OP_T1:
            begin
                r0 = sat_add(a_re_reg, a_re_reg);
                r1 = sat_add(a_im_reg, a_im_reg);
                r2 = sat_add(crit_re, crit_re);
                r3 = sat_add(crit_im, crit_im);
                t_re_next = r0.val;
                t_im_next = r1.val;
                f_re_next = r2.val;
                f_im_next = r3.val;
                bsat_next = bsat_reg | r0.sat | r1.sat | r2.sat | r3.sat;
            end
            OP_T2:
            begin
                r0 = sat_add(t_re_reg, a_re_reg);
                r1 = sat_add(t_im_reg, a_im_reg);
                r2 = sat_add(f_re_reg, f_re_reg);
                r3 = sat_add(f_im_reg, f_im_reg);
                t_re_next = r0.val;
                t_im_next = r1.val;
                f_re_next = r2.val;
                f_im_next = r3.val;
                bsat_next = bsat_reg | r0.sat | r1.sat | r2.sat | r3.sat;
            end
            OP_T3:
            begin
                r0 = sat_sub(t_re_reg, f_re_reg);
                r1 = sat_sub(t_im_reg, f_im_reg);
                t_re_next = r0.val;
                t_im_next = r1.val;
                bsat_next = bsat_reg | r0.sat | r1.sat;
            end
            OP_CMB_N:
            begin
                n_re_next = cmb_re.val;
                n_im_next = cmb_im.val;
                bsat_next = bsat_reg | cmb_sat;
            end
            OP_ADD_NL:
            begin
                r0 = sat_add(n_re_reg, mult_re);
                r1 = sat_add(n_im_reg, mult_im);
                n_re_next = r0.val;
                n_im_next = r1.val;
                bsat_next = bsat_reg | r0.sat | r1.sat;
            end
            OP_DSUM:
            begin
                mr_next   = sum_r.mag;
                mi_next   = sum_i.mag;
                // b is the negated quotient.
                negr_next = ~sum_r.neg && (sum_r.mag != '0);
                negi_next = ~sum_i.neg && (sum_i.mag != '0);
            end
            OP_DEN:
            begin
                den_next = prod0_reg + prod1_reg;
            end
            OP_B:
            begin
                r0 = sat_mag(negr_reg, {big_re, {(MW-DATA_WIDTH-2){1'b0}}, quot_re});
                r1 = sat_mag(negi_reg, {big_im, {(MW-DATA_WIDTH-2){1'b0}}, quot_im});
                b_re_next = r0.val;
                b_im_next = r1.val;
                bsat_next = bsat_reg | r0.sat | r1.sat;
            end
            OP_BZERO:
            begin
                b_re_next = '0;
                b_im_next = '0;
                bsat_next = 1'b1;
            end
            OP_PINIT:
            begin
                p_re_next  = crit_re;
                p_im_next  = crit_im;
                count_next = '0;
                s_next     = 1'b0;
            end
            OP_XSUB:
            begin
                r0 = sat_sub(a_re_reg, p_re_reg);
                r1 = sat_sub(a_im_reg, p_im_reg);
                x_re_next = r0.val;
                x_im_next = r1.val;
                s_next    = bsat_reg | r0.sat | r1.sat;
            end
            OP_CMB_X:
            begin
                x_re_next = cmb_re.val;
                x_im_next = cmb_im.val;
                s_next    = s_reg | cmb_sat;
            end
            OP_ADD_XB:
            begin
                r0 = sat_add(x_re_reg, b_re_reg);
                r1 = sat_add(x_im_reg, b_im_reg);
                x_re_next = r0.val;
                x_im_next = r1.val;
                s_next    = s_reg | r0.sat | r1.sat;
            end
            OP_ADD_XL:
            begin
                r0 = sat_add(x_re_reg, mult_re);
                r1 = sat_add(x_im_reg, mult_im);
                x_re_next = r0.val;
                x_im_next = r1.val;
                s_next    = s_reg | r0.sat | r1.sat;
            end
            OP_CMB_P:
            begin
                p_re_next  = cmb_re.val;
                p_im_next  = cmb_im.val;
                s_next     = s_reg | cmb_sat;
                count_next = count_reg + COUNT_WIDTH'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsat_reg  <= 1'b0;
            s_reg     <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            bsat_reg  <= bsat_next;
            s_reg     <= s_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_re_reg  <= a_re_next;
        a_im_reg  <= a_im_next;
        t_re_reg  <= t_re_next;
        t_im_reg  <= t_im_next;
        f_re_reg  <= f_re_next;
        f_im_reg  <= f_im_next;
        n_re_reg  <= n_re_next;
        n_im_reg  <= n_im_next;
        x_re_reg  <= x_re_next;
        x_im_reg  <= x_im_next;
        p_re_reg  <= p_re_next;
        p_im_reg  <= p_im_next;
        b_re_reg  <= b_re_next;
        b_im_reg  <= b_im_next;
        mr_reg    <= mr_next;
        mi_reg    <= mi_next;
        negr_reg  <= negr_next;
        negi_reg  <= negi_next;
        den_reg   <= den_next;
    end

    assign status.outside   = (osum >> (2 * FRAC_BITS)) >= ESC_RADIUS_SQ;
    assign status.escaped   = s_reg;
    assign status.limit_hit = (count_reg >= max_iterations);
    assign status.den_zero  = (den_reg == '0);
    assign status.div_done  = done_re & done_im;

    assign escape_count   = count_reg;
    assign stayed_bounded = status.limit_hit;

endmodule

// ----- src/qet_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qet_ctrl
// Controller: sequences the offset set-up, the divide and the escape-time
// loop, and raises the result strobe.
// ----------------------------------------------------------------------------
module qet_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  qet_pkg::dp_status_t status,
    output qet_pkg::op_t        cmd,
    output logic                busy,
    output logic                done
);
    import qet_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_T1    = 5'd1;
    localparam logic [4:0] S_T2    = 5'd2;
    localparam logic [4:0] S_T3    = 5'd3;
    localparam logic [4:0] S_MTC   = 5'd4;
    localparam logic [4:0] S_CN1   = 5'd5;
    localparam logic [4:0] S_MNC1  = 5'd6;
    localparam logic [4:0] S_CN2   = 5'd7;
    localparam logic [4:0] S_ADDL  = 5'd8;
    localparam logic [4:0] S_MNC2  = 5'd9;
    localparam logic [4:0] S_DSUM  = 5'd10;
    localparam logic [4:0] S_MCC   = 5'd11;
    localparam logic [4:0] S_DEN   = 5'd12;
    localparam logic [4:0] S_DCHK  = 5'd13;
    localparam logic [4:0] S_DIVW  = 5'd14;
    localparam logic [4:0] S_PINIT = 5'd15;
    localparam logic [4:0] S_MPP   = 5'd16;
    localparam logic [4:0] S_CHK   = 5'd17;
    localparam logic [4:0] S_XSUB  = 5'd18;
    localparam logic [4:0] S_MXP1  = 5'd19;
    localparam logic [4:0] S_CX1   = 5'd20;
    localparam logic [4:0] S_ADDB  = 5'd21;
    localparam logic [4:0] S_MXP2  = 5'd22;
    localparam logic [4:0] S_CX2   = 5'd23;
    localparam logic [4:0] S_ADDLX = 5'd24;
    localparam logic [4:0] S_MXP3  = 5'd25;
    localparam logic [4:0] S_CP    = 5'd26;
    localparam logic [4:0] S_FIN   = 5'd27;

    logic [4:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = OP_IDLE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd        = OP_LOAD;
                    state_next = S_T1;
                end
            end
            S_T1:   begin cmd = OP_T1;     state_next = S_T2;   end
            S_T2:   begin cmd = OP_T2;     state_next = S_T3;   end
            S_T3:   begin cmd = OP_T3;     state_next = S_MTC;  end
            S_MTC:  begin cmd = OP_MUL_TC; state_next = S_CN1;  end
            S_CN1:  begin cmd = OP_CMB_N;  state_next = S_MNC1; end
            S_MNC1: begin cmd = OP_MUL_NC; state_next = S_CN2;  end
            S_CN2:  begin cmd = OP_CMB_N;  state_next = S_ADDL; end
            S_ADDL: begin cmd = OP_ADD_NL; state_next = S_MNC2; end
            S_MNC2: begin cmd = OP_MUL_NC; state_next = S_DSUM; end
            S_DSUM: begin cmd = OP_DSUM;   state_next = S_MCC;  end
            S_MCC:  begin cmd = OP_MUL_CC; state_next = S_DEN;  end
            S_DEN:  begin cmd = OP_DEN;    state_next = S_DCHK; end
            S_DCHK:
            begin
                // A zero critical point has no quotient: b counts as saturated.
                if (status.den_zero)
                begin
                    cmd        = OP_BZERO;
                    state_next = S_PINIT;
                end
                else
                begin
                    cmd        = OP_DIV_START;
                    state_next = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (status.div_done)
                begin
                    cmd        = OP_B;
                    state_next = S_PINIT;
                end
            end
            S_PINIT: begin cmd = OP_PINIT;  state_next = S_MPP;  end
            S_MPP:   begin cmd = OP_MUL_PP; state_next = S_CHK;  end
            S_CHK:
            begin
                if (status.limit_hit || status.escaped || status.outside)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_XSUB;
                end
            end
            S_XSUB:  begin cmd = OP_XSUB;   state_next = S_MXP1;  end
            S_MXP1:  begin cmd = OP_MUL_XP; state_next = S_CX1;   end
            S_CX1:   begin cmd = OP_CMB_X;  state_next = S_ADDB;  end
            S_ADDB:  begin cmd = OP_ADD_XB; state_next = S_MXP2;  end
            S_MXP2:  begin cmd = OP_MUL_XP; state_next = S_CX2;   end
            S_CX2:   begin cmd = OP_CMB_X;  state_next = S_ADDLX; end
            S_ADDLX: begin cmd = OP_ADD_XL; state_next = S_MXP3;  end
            S_MXP3:  begin cmd = OP_MUL_XP; state_next = S_CP;    end
            S_CP:    begin cmd = OP_CMB_P;  state_next = S_MPP;   end
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_FIN);

endmodule

// ----- src/qet_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qet_chk
// Port-level checks on the command handshake and result strobe.
// ----------------------------------------------------------------------------
module qet_chk (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic pready
);

    // The strobe only ever appears while a command is in progress.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a command");

    // One beat per command: the strobe never repeats back to back.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // An accepted command raises busy once the sequencer leaves idle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // Busy never rises without a start request.
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind quartic_escape_time_top qet_chk u_qet_chk (.*);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for quartic_escape_time_top. An independent fixed-point
// predictor forms the offset b and runs the escape-time loop for each accepted
// point; every done beat is compared with the oldest prediction. Directed
// tests cover the register defaults, field extremes, a zero limit, a zero
// critical point and the limit extremes; random phases follow with fresh
// settings written over the APB port while the block is idle.
// ----------------------------------------------------------------------------
module tb;
    import qet_pkg::*;

    localparam int WATCHDOG_LIMIT = 50000;

    typedef struct packed {
        count_t cnt;
        logic   bnd;
    } escape_t;

    typedef struct packed {
        fix_t re;
        fix_t im;
    } cplx_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    fix_t point_re;
    fix_t point_im;
    logic done;
    count_t escape_count;
    logic stayed_bounded;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_WIDTH-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    // Settings as the predictor sees them.
    fix_t   cfg_crit_re = fix_t'(32'sh1000_0000);
    fix_t   cfg_crit_im = '0;
    fix_t   cfg_mult_re = fix_t'(32'sh1000_0000);
    fix_t   cfg_mult_im = '0;
    count_t cfg_limit   = MAX_ITER_RESET;

    escape_t pending_counts[$];
    int      errors = 0;
    int      idle_cycles = 0;
    logic    steady = 1'b0;
    logic    ovf;

    quartic_escape_time_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .point_re(point_re), .point_im(point_im), .done(done),
        .escape_count(escape_count), .stayed_bounded(stayed_bounded),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 clk = ~clk;

    // ---------------- fixed-point predictor ----------------
    function automatic logic [31:0] absv(input fix_t x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    function fix_t clamp_mag(input logic neg, input logic [191:0] mag);
        if (!neg)
        begin
            if (mag > 192'h7fff_ffff)
            begin
                ovf = 1'b1;
                return FIX_MAX;
            end
            return fix_t'(mag[31:0]);
        end
        if (mag > 192'h8000_0000)
        begin
            ovf = 1'b1;
            return FIX_MIN;
        end
        return fix_t'(32'd0 - mag[31:0]);
    endfunction

    function fix_t add_s(input fix_t x, input fix_t y);
        logic [32:0] s;
        s = {x[31], x} + {y[31], y};
        if (s[32] != s[31])
        begin
            ovf = 1'b1;
            return s[32] ? FIX_MIN : FIX_MAX;
        end
        return fix_t'(s[31:0]);
    endfunction

    function fix_t sub_s(input fix_t x, input fix_t y);
        logic [32:0] s;
        s = {x[31], x} - {y[31], y};
        if (s[32] != s[31])
        begin
            ovf = 1'b1;
            return s[32] ? FIX_MIN : FIX_MAX;
        end
        return fix_t'(s[31:0]);
    endfunction

    function fix_t mul_s(input fix_t x, input fix_t y);
        logic [63:0] m;
        m = absv(x) * absv(y);
        return clamp_mag(x[31] ^ y[31], 192'(m >> FRAC_BITS));
    endfunction

    function cplx_t cmul_s(input cplx_t x, input cplx_t y);
        fix_t a, b, c, d;
        cplx_t r;
        a = mul_s(x.re, y.re);
        b = mul_s(x.im, y.im);
        c = mul_s(x.re, y.im);
        d = mul_s(x.im, y.re);
        r.re = sub_s(a, b);
        r.im = add_s(c, d);
        return r;
    endfunction

    // One component of -num*conj(c)/(2|c|^2): signed sum of two exact products,
    // scaled by 2^(FRAC_BITS-1) and divided, truncating toward zero.
    function fix_t offset_part(input logic n1, input logic [63:0] m1,
                               input logic n2, input logic [63:0] m2,
                               input logic [191:0] den);
        logic           neg;
        logic [191:0]   mag;
        if (n1 == n2)
        begin
            neg = n1;
            mag = 192'(m1) + 192'(m2);
        end
        else if (m1 >= m2)
        begin
            neg = n1;
            mag = 192'(m1 - m2);
        end
        else
        begin
            neg = n2;
            mag = 192'(m2 - m1);
        end
        return clamp_mag(!neg && mag != 0, (mag << (FRAC_BITS - 1)) / den);
    endfunction

    function logic escaped_radius(input cplx_t p);
        logic [191:0] n;
        n = 192'(absv(p.re)) * 192'(absv(p.re)) + 192'(absv(p.im)) * 192'(absv(p.im));
        return (n >> (2 * FRAC_BITS)) >= 192'd1000;
    endfunction

    function escape_t predict_escape(input fix_t ar, input fix_t ai);
        cplx_t a, c, lam, t, f, num, b, p, x;
        logic [191:0] den;
        logic bsat, gone;
        int unsigned steps;
        escape_t r;
        a = '{ar, ai};
        c = '{cfg_crit_re, cfg_crit_im};
        lam = '{cfg_mult_re, cfg_mult_im};
        b = '0;
        ovf = 1'b0;
        t.re = add_s(add_s(ar, ar), ar);
        t.im = add_s(add_s(ai, ai), ai);
        f.re = add_s(c.re, c.re);
        f.im = add_s(c.im, c.im);
        f.re = add_s(f.re, f.re);
        f.im = add_s(f.im, f.im);
        t.re = sub_s(t.re, f.re);
        t.im = sub_s(t.im, f.im);
        num = cmul_s(t, c);
        num = cmul_s(num, c);
        num.re = add_s(num.re, lam.re);
        num.im = add_s(num.im, lam.im);
        den = 192'(absv(c.re)) * 192'(absv(c.re)) + 192'(absv(c.im)) * 192'(absv(c.im));
        if (den == 0)
        begin
            ovf = 1'b1;
        end
        else
        begin
            b.re = offset_part(num.re[31] ^ c.re[31], absv(num.re) * absv(c.re),
                               num.im[31] ^ c.im[31], absv(num.im) * absv(c.im), den);
            b.im = offset_part(num.im[31] ^ c.re[31], absv(num.im) * absv(c.re),
                               !(num.re[31] ^ c.im[31]), absv(num.re) * absv(c.im), den);
        end
        bsat = ovf;
        p = c;
        steps = 0;
        gone = 1'b0;
        while (steps < cfg_limit && !gone && !escaped_radius(p))
        begin
            ovf = bsat;
            x.re = sub_s(a.re, p.re);
            x.im = sub_s(a.im, p.im);
            x = cmul_s(x, p);
            x.re = add_s(x.re, b.re);
            x.im = add_s(x.im, b.im);
            x = cmul_s(x, p);
            x.re = add_s(x.re, lam.re);
            x.im = add_s(x.im, lam.im);
            p = cmul_s(x, p);
            steps++;
            gone = ovf;
        end
        r.cnt = count_t'(steps);
        r.bnd = (steps >= cfg_limit);
        return r;
    endfunction

    // ---------------- checking ----------------
    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_counts.size() == 0)
            begin
                report("unexpected result beat", escape_count, -1);
            end
            else
            begin
                escape_t e;
                e = pending_counts.pop_front();
                if (escape_count !== e.cnt)
                begin
                    report("escape_count", escape_count, e.cnt);
                end
                if (stayed_bounded !== e.bnd)
                begin
                    report("stayed_bounded", stayed_bounded, e.bnd);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic send_point(input fix_t re, input fix_t im);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_re <= re;
        point_im <= im;
        start <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        pending_counts.push_back(predict_escape(re, im));
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_counts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_WIDTH-1:0] idx, input logic [31:0] value);
        paddr <= {idx, 2'b00};
        pwdata <= value;
        pwrite <= 1'b1;
        psel <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_CRIT_RE:  cfg_crit_re = fix_t'(value);
            REG_CRIT_IM:  cfg_crit_im = fix_t'(value);
            REG_MULT_RE:  cfg_mult_re = fix_t'(value);
            REG_MULT_IM:  cfg_mult_im = fix_t'(value);
            REG_MAX_ITER: cfg_limit   = count_t'(value);
            default: ;
        endcase
    endtask

    task automatic configure(input fix_t cr, input fix_t ci, input fix_t lr, input fix_t li,
                             input count_t lim);
        wait_idle();
        write_reg(REG_CRIT_RE, cr);
        write_reg(REG_CRIT_IM, ci);
        write_reg(REG_MULT_RE, lr);
        write_reg(REG_MULT_IM, li);
        write_reg(REG_MAX_ITER, 32'(lim));
    endtask

    function automatic fix_t near(input int span);
        return fix_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic fix_t any_point();
        return ($urandom_range(0, 4) == 0) ? fix_t'($urandom) : near(32'sh2000_0000);
    endfunction

    task automatic test_defaults();
        send_point(FIX_MAX, FIX_MAX);
        send_point(FIX_MIN, FIX_MIN);
        send_point('0, '0);
        send_point(FIX_MAX, FIX_MIN);
        send_point(fix_t'(32'sh1000_0000), '0);
        send_point(fix_t'(32'shf000_0000), fix_t'(32'sh0800_0000));
        send_point(fix_t'(32'h5555_5555), fix_t'(32'haaaa_aaaa));
        send_point(fix_t'(32'haaaa_aaaa), fix_t'(32'h5555_5555));
    endtask

    task automatic test_zero_limit();
        configure(fix_t'(32'sh1000_0000), '0, fix_t'(32'sh1000_0000), '0, '0);
        send_point('0, '0);
        send_point(FIX_MAX, FIX_MIN);
    endtask

    task automatic test_zero_crit();
        configure('0, '0, fix_t'(32'sh0800_0000), '0, count_t'(30));
        send_point('0, '0);
        send_point(fix_t'(32'sh0400_0000), fix_t'(32'shfc00_0000));
    endtask

    task automatic test_extremes();
        configure(FIX_MAX, FIX_MIN, FIX_MIN, FIX_MAX, count_t'(1));
        send_point('0, '0);
        send_point(FIX_MIN, FIX_MAX);
        // A huge point with the widest limit saturates the offset at once.
        configure(fix_t'(32'sh1000_0000), '0, fix_t'(32'sh1000_0000), '0, '1);
        send_point(FIX_MAX, FIX_MAX);
        send_point(FIX_MIN, FIX_MIN);
        // A write beyond the register map must leave the settings alone.
        wait_idle();
        paddr <= 5'd20;
        pwdata <= '1;
        pwrite <= 1'b1;
        psel <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        configure(fix_t'(32'shf000_0000), fix_t'(32'sh0400_0000), fix_t'(32'sh0c00_0000),
                  fix_t'(32'shfe00_0000), count_t'(12));
        send_point(fix_t'(32'sh0200_0000), fix_t'(32'shfe00_0000));
        send_point(FIX_MAX, '0);
    endtask

    task automatic test_random();
        fix_t cr, ci;
        count_t lim;
        for (int ph = 0; ph < 14; ph++)
        begin
            cr = ($urandom_range(0, 5) == 0) ? fix_t'($urandom) : near(32'sh1800_0000);
            ci = ($urandom_range(0, 5) == 0) ? fix_t'($urandom) : near(32'sh1000_0000);
            lim = (ph == 3) ? '0 : count_t'($urandom_range(1, 40));
            configure(cr, ci, near(32'sh1000_0000), near(32'sh1000_0000), lim);
            steady = (ph % 4 == 1);
            for (int k = 0; k < 100; k++)
            begin
                send_point(any_point(), any_point());
            end
            steady = 1'b0;
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        point_re <= '0;
        point_im <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_zero_limit();
        test_zero_crit();
        test_extremes();
        test_random();
        wait_idle();
        repeat (100) @(posedge clk);
        if (errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
